// ----- hdl/bsa_pkg.sv -----
package bsa_pkg;

    localparam int TOTAL_LEVELS = 10;
    localparam int MAX_OWNERS   = 64;
    localparam int NODE_W       = TOTAL_LEVELS + 1;
    localparam int ADDR_W       = NODE_W + 1;
    localparam int REC_W        = TOTAL_LEVELS + 2;
    localparam int DEPTH_W      = 4;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_REALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE    = 2'd2;
    localparam logic [1:0] FUNC_RSVD    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;

    localparam logic [1:0] NS_UNUSED = 2'd0;
    localparam logic [1:0] NS_FREE   = 2'd1;
    localparam logic [1:0] NS_ALLOC  = 2'd2;
    localparam logic [1:0] NS_SPLIT  = 2'd3;

    localparam logic CFG_REGION = 1'b0;
    localparam logic CFG_UNIT   = 1'b1;

    typedef struct packed {
        logic       in_slab;
        logic [9:0] offset;
        logic [3:0] block_log2;
    } t_desc;

endpackage

// ----- hdl/bsa_if.sv -----
interface bsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  owner_id;
    logic [10:0] size_units;
    modport source (output valid, func, owner_id, size_units, input ready);
    modport sink   (input valid, func, owner_id, size_units, output ready);
endinterface

interface bsa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       in_slab;
    logic [9:0] offset;
    logic [3:0] block_log2;
    logic       unchanged;
    modport source (output valid, status, in_slab, offset, block_log2, unchanged, input ready);
    modport sink   (input valid, status, in_slab, offset, block_log2, unchanged, output ready);
endinterface

interface bsa_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/buddy_slab_allocator.sv -----
// Path to result: unknown func or no block held goes straight to S_DONE; reallocate in place
// reads the owner record (S_ORD, S_OD); free steps S_REL_W, S_REL_CK, S_REL_M1, S_REL_M2 per
// merged level; allocate reads then checks each node it scans (S_T_RD, S_T_CK). A stalled result adds its wait.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset and every configuration write run a clearing pass over all 2^(TOTAL_LEVELS+2) entries
// of the node-state memory, during which no request is taken.
module buddy_slab_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsa_req_if.sink    i_req,
    bsa_rsp_if.source  o_rsp,
    bsa_cfg_if.sink    i_cfg
);

    localparam int NW = bsa_pkg::NODE_W;
    localparam int AW = bsa_pkg::ADDR_W;
    localparam int DW = bsa_pkg::DEPTH_W;
    localparam logic [DW-1:0] LEVELS = DW'(bsa_pkg::TOTAL_LEVELS);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_ORD    = 5'd2;
    localparam logic [4:0] S_OD     = 5'd3;
    localparam logic [4:0] S_REL_W  = 5'd4;
    localparam logic [4:0] S_REL_CK = 5'd5;
    localparam logic [4:0] S_REL_M1 = 5'd6;
    localparam logic [4:0] S_REL_M2 = 5'd7;
    localparam logic [4:0] S_PL     = 5'd8;
    localparam logic [4:0] S_T_RD   = 5'd9;
    localparam logic [4:0] S_T_CK   = 5'd10;
    localparam logic [4:0] S_T_SP1  = 5'd11;
    localparam logic [4:0] S_T_SP2  = 5'd12;
    localparam logic [4:0] S_T_ALC  = 5'd13;
    localparam logic [4:0] S_DONE   = 5'd14;

    function automatic logic [DW-1:0] msb_idx(input logic [NW:0] v);
        logic [DW-1:0] r;
        r = '0;
        for (int i = 0; i <= NW; i++) begin
            if (v[i]) r = DW'(i);
        end
        return r;
    endfunction

    function automatic logic [1:0] init_state(input logic [AW-1:0] a,
                                              input logic [DW-1:0] d0);
        logic [NW-1:0] n;
        logic [NW-1:0] m;
        logic [DW-1:0] j;
        logic [1:0]    s;
        n = a[NW-1:0];
        m = n - NW'(1);
        s = bsa_pkg::NS_UNUSED;
        if (a[AW-1]) begin
            if (n == NW'(1)) s = bsa_pkg::NS_FREE;
        end else if (n != '0 && (n & m) == '0) begin
            j = msb_idx({1'b0, n});
            if (j < d0) s = bsa_pkg::NS_SPLIT;
            else if (j == d0) s = bsa_pkg::NS_ALLOC;
        end else if (n >= NW'(3) && (m & (m - NW'(1))) == '0) begin
            j = msb_idx({1'b0, m});
            if (j <= d0) s = bsa_pkg::NS_FREE;
        end
        return s;
    endfunction

    function automatic bsa_pkg::t_desc describe(input logic [bsa_pkg::REC_W-1:0] rec,
                                                input logic [DW-1:0] reg_lv);
        bsa_pkg::t_desc r;
        logic [NW-1:0]  n;
        logic [DW-1:0]  tl;
        logic [DW-1:0]  d;
        logic [NW-1:0]  rel;
        n  = rec[NW-1:0];
        tl = rec[NW] ? reg_lv : LEVELS;
        d  = msb_idx({1'b0, n});
        if (d > tl) d = tl;
        rel = (n - (NW'(1) << d)) << (tl - d);
        r.in_slab    = rec[NW];
        r.offset     = rel[9:0];
        r.block_log2 = tl - d;
        return r;
    endfunction

    logic [1:0]  r_mem [0:(2**AW)-1];
    logic [1:0]  r_rd;
    logic [bsa_pkg::REC_W-1:0] r_own_mem [0:bsa_pkg::MAX_OWNERS-1];
    logic [bsa_pkg::REC_W-1:0] r_own_rd;
    logic [bsa_pkg::MAX_OWNERS-1:0] r_own_v;

    logic [3:0]    r_cfg_r;
    logic [3:0]    r_cfg_u;
    logic [4:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_func;
    logic [5:0]    r_owner;
    logic [DW-1:0] r_k;
    logic [bsa_pkg::REC_W-1:0] r_rec;
    logic          r_tree;
    logic [NW-1:0] r_n;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_dt;
    logic [1:0]    r_pass;
    logic          r_rel_pl;

    logic [1:0]    r_st;
    logic          r_slab;
    logic [9:0]    r_off;
    logic [3:0]    r_blog;
    logic          r_unch;

    logic          r_ov;
    logic [1:0]    r_o_st;
    logic          r_o_slab;
    logic [9:0]    r_o_off;
    logic [3:0]    r_o_blog;
    logic          r_o_unch;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [1:0]    w_wd;
    logic          w_re;
    logic [AW-1:0] w_ra;

    logic [DW-1:0] w_reg_lv;
    logic [DW-1:0] w_d0;
    logic [DW-1:0] w_kin;
    logic [NW:0]   w_szm;
    logic          w_first;
    logic          w_ps;
    logic [DW-1:0] w_tl;
    logic [NW-1:0] w_sib;
    logic          w_last;
    logic [NW:0]   w_endm;
    bsa_pkg::t_desc w_od;
    bsa_pkg::t_desc w_ad;

    assign w_reg_lv = (r_cfg_r > LEVELS) ? LEVELS : r_cfg_r;
    assign w_d0     = LEVELS - w_reg_lv;
    assign w_szm    = {1'b0, i_req.size_units} - (NW+1)'(1);
    assign w_kin    = (i_req.size_units <= 11'd1) ? '0 : msb_idx(w_szm) + DW'(1);
    assign w_first  = (r_k == r_cfg_u);
    assign w_ps     = r_pass[0] ? ~w_first : w_first;
    assign w_tl     = w_ps ? w_reg_lv : LEVELS;
    assign w_sib    = r_n ^ NW'(1);
    assign w_endm   = ((NW+1)'(1) << (r_d + DW'(1))) - (NW+1)'(1);
    assign w_last   = ({1'b0, r_n} == w_endm);
    assign w_od     = describe(r_rec, w_reg_lv);
    assign w_ad     = describe({r_tree, r_n}, w_reg_lv);

    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_o_st;
    assign o_rsp.in_slab    = r_o_slab;
    assign o_rsp.offset     = r_o_off;
    assign o_rsp.block_log2 = r_o_blog;
    assign o_rsp.unchanged  = r_o_unch;

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = bsa_pkg::NS_UNUSED;
        w_re = 1'b0;
        w_ra = '0;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = init_state(r_clr, w_d0);
            end
            S_REL_W: begin
                w_we = 1'b1;
                w_wa = {r_tree, r_n};
                w_wd = bsa_pkg::NS_FREE;
                w_re = 1'b1;
                w_ra = {r_tree, w_sib};
            end
            S_REL_M1: begin
                w_we = 1'b1;
                w_wa = {r_tree, r_n};
            end
            S_REL_M2: begin
                w_we = 1'b1;
                w_wa = {r_tree, w_sib};
            end
            S_T_RD: begin
                w_re = 1'b1;
                w_ra = {r_tree, r_n};
            end
            S_T_SP1: begin
                w_we = 1'b1;
                w_wa = {r_tree, r_n};
                w_wd = bsa_pkg::NS_SPLIT;
            end
            S_T_SP2: begin
                w_we = 1'b1;
                w_wa = {r_tree, r_n[NW-2:0], 1'b1};
                w_wd = bsa_pkg::NS_FREE;
            end
            S_T_ALC: begin
                w_we = 1'b1;
                w_wa = {r_tree, r_n};
                w_wd = bsa_pkg::NS_ALLOC;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_ra];
        if (r_state == S_T_ALC) r_own_mem[r_owner] <= {r_tree, r_n};
        r_own_rd <= r_own_mem[i_req.owner_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_r  <= 4'd8;
            r_cfg_u  <= 4'd4;
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_own_v  <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_DONE || i_cfg.valid)) r_ov <= 1'b0;
            // a register write rebuilds both trees and drops every owner record
            if (i_cfg.valid) begin
                if (i_cfg.index == bsa_pkg::CFG_REGION) r_cfg_r <= i_cfg.data;
                else r_cfg_u <= i_cfg.data;
                r_state <= S_CLR;
                r_clr   <= '0;
                r_own_v <= '0;
            end else begin
                case (r_state)
                    S_CLR: begin
                        r_clr <= r_clr + AW'(1);
                        if (r_clr == '1) r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_req.valid) begin
                            r_func  <= i_req.func;
                            r_owner <= i_req.owner_id;
                            r_k     <= w_kin;
                            r_pass  <= '0;
                            r_st    <= bsa_pkg::ST_NO_BLOCK;
                            r_slab  <= 1'b0;
                            r_off   <= '0;
                            r_blog  <= '0;
                            r_unch  <= 1'b0;
                            if (i_req.func == bsa_pkg::FUNC_ALLOC) begin
                                if (32'(i_req.owner_id) >= bsa_pkg::MAX_OWNERS) begin
                                    r_st    <= bsa_pkg::ST_NO_SPACE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_PL;
                                end
                            end else if (i_req.func == bsa_pkg::FUNC_RSVD
                                         || !r_own_v[i_req.owner_id]) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ORD;
                            end
                        end
                    end
                    S_ORD: begin
                        r_rec   <= r_own_rd;
                        r_state <= S_OD;
                    end
                    S_OD: begin
                        r_tree <= r_rec[NW];
                        r_n    <= r_rec[NW-1:0];
                        if (r_func == bsa_pkg::FUNC_FREE) begin
                            r_st     <= bsa_pkg::ST_OK;
                            r_slab   <= w_od.in_slab;
                            r_off    <= w_od.offset;
                            r_blog   <= w_od.block_log2;
                            r_rel_pl <= 1'b0;
                            r_state  <= S_REL_W;
                        end else if (w_od.block_log2 == r_k) begin
                            r_st    <= bsa_pkg::ST_OK;
                            r_slab  <= w_od.in_slab;
                            r_off   <= w_od.offset;
                            r_blog  <= w_od.block_log2;
                            r_unch  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_rel_pl <= 1'b1;
                            r_state  <= S_REL_W;
                        end
                    end
                    S_REL_W: begin
                        if (r_n == NW'(1)) begin
                            r_own_v[r_owner] <= 1'b0;
                            r_state <= r_rel_pl ? S_PL : S_DONE;
                        end else begin
                            r_state <= S_REL_CK;
                        end
                    end
                    S_REL_CK: begin
                        if (r_rd == bsa_pkg::NS_FREE) begin
                            r_state <= S_REL_M1;
                        end else begin
                            r_own_v[r_owner] <= 1'b0;
                            r_state <= r_rel_pl ? S_PL : S_DONE;
                        end
                    end
                    S_REL_M1: r_state <= S_REL_M2;
                    S_REL_M2: begin
                        r_n     <= r_n >> 1;
                        r_state <= S_REL_W;
                    end
                    S_PL: begin
                        if (r_pass == 2'd2) begin
                            r_st    <= bsa_pkg::ST_NO_SPACE;
                            r_state <= S_DONE;
                        end else if (r_k <= w_tl) begin
                            r_tree  <= w_ps;
                            r_dt    <= w_tl - r_k;
                            r_d     <= w_tl - r_k;
                            r_n     <= NW'(1) << (w_tl - r_k);
                            r_state <= S_T_RD;
                        end else begin
                            r_pass <= r_pass + 2'd1;
                        end
                    end
                    S_T_RD: r_state <= S_T_CK;
                    S_T_CK: begin
                        if (r_rd == bsa_pkg::NS_FREE) begin
                            r_state <= (r_d == r_dt) ? S_T_ALC : S_T_SP1;
                        end else if (w_last) begin
                            if (r_d == '0) begin
                                r_pass  <= r_pass + 2'd1;
                                r_state <= S_PL;
                            end else begin
                                r_d     <= r_d - DW'(1);
                                r_n     <= NW'(1) << (r_d - DW'(1));
                                r_state <= S_T_RD;
                            end
                        end else begin
                            r_n     <= r_n + NW'(1);
                            r_state <= S_T_RD;
                        end
                    end
                    S_T_SP1: r_state <= S_T_SP2;
                    S_T_SP2: begin
                        r_n     <= {r_n[NW-2:0], 1'b0};
                        r_d     <= r_d + DW'(1);
                        r_state <= (r_d + DW'(1) == r_dt) ? S_T_ALC : S_T_SP1;
                    end
                    S_T_ALC: begin
                        r_own_v[r_owner] <= 1'b1;
                        r_st    <= bsa_pkg::ST_OK;
                        r_slab  <= w_ad.in_slab;
                        r_off   <= w_ad.offset;
                        r_blog  <= w_ad.block_log2;
                        r_unch  <= 1'b0;
                        r_state <= S_DONE;
                    end
                    S_DONE: begin
                        if (!r_ov || o_rsp.ready) begin
                            r_ov     <= 1'b1;
                            r_o_st   <= r_st;
                            r_o_slab <= r_slab;
                            r_o_off  <= r_off;
                            r_o_blog <= r_blog;
                            r_o_unch <= r_unch;
                            r_state  <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;

    localparam int TOTAL_LEVELS = bsa_pkg::TOTAL_LEVELS;
    localparam int MAX_OWNERS = bsa_pkg::MAX_OWNERS;
    localparam int NODE_W = bsa_pkg::NODE_W;
    localparam int REC_W = bsa_pkg::REC_W;
    localparam int NODES = 1 << (TOTAL_LEVELS + 1);
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [1:0] status;
        logic       in_slab;
        logic [9:0] offset;
        logic [3:0] block_log2;
        logic       unchanged;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bsa_req_if req_if ();
    bsa_rsp_if rsp_if ();
    bsa_cfg_if cfg_if ();

    buddy_slab_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow allocator state
    logic [1:0]        main_tree [NODES];
    logic [1:0]        slab_tree [NODES];
    logic              owner_held [MAX_OWNERS];
    logic [REC_W-1:0]  owner_rec [MAX_OWNERS];
    logic [3:0]        region_cfg;
    logic [3:0]        unit_cfg;

    t_grant pending_grants[$];
    int     error_count;
    int     idle_cycles;
    bit     timed_out;

    function automatic int region_depth();
        return (region_cfg > TOTAL_LEVELS) ? TOTAL_LEVELS : int'(region_cfg);
    endfunction

    function automatic int depth_of(int n);
        int d;
        d = 0;
        while (n > 1) begin
            n = n >> 1;
            d++;
        end
        return d;
    endfunction

    function automatic int take_block(bit slab, int depth);
        int n;
        int cur;
        for (n = 1 << depth; n < (2 << depth); n++) begin
            if ((slab ? slab_tree[n] : main_tree[n]) == bsa_pkg::NS_FREE) begin
                if (slab) slab_tree[n] = bsa_pkg::NS_ALLOC;
                else main_tree[n] = bsa_pkg::NS_ALLOC;
                return n;
            end
        end
        for (int d = depth - 1; d >= 0; d--) begin
            for (n = 1 << d; n < (2 << d); n++) begin
                if ((slab ? slab_tree[n] : main_tree[n]) == bsa_pkg::NS_FREE) begin
                    cur = d;
                    while (cur < depth) begin
                        if (slab) begin
                            slab_tree[n] = bsa_pkg::NS_SPLIT;
                            slab_tree[2*n+1] = bsa_pkg::NS_FREE;
                        end else begin
                            main_tree[n] = bsa_pkg::NS_SPLIT;
                            main_tree[2*n+1] = bsa_pkg::NS_FREE;
                        end
                        n = 2 * n;
                        cur++;
                    end
                    if (slab) slab_tree[n] = bsa_pkg::NS_ALLOC;
                    else main_tree[n] = bsa_pkg::NS_ALLOC;
                    return n;
                end
            end
        end
        return 0;
    endfunction

    function automatic void release_block(bit slab, int n);
        if (slab) slab_tree[n] = bsa_pkg::NS_FREE;
        else main_tree[n] = bsa_pkg::NS_FREE;
        while (n > 1 && (slab ? slab_tree[n^1] : main_tree[n^1]) == bsa_pkg::NS_FREE) begin
            if (slab) begin
                slab_tree[n] = bsa_pkg::NS_UNUSED;
                slab_tree[n^1] = bsa_pkg::NS_UNUSED;
                slab_tree[n>>1] = bsa_pkg::NS_FREE;
            end else begin
                main_tree[n] = bsa_pkg::NS_UNUSED;
                main_tree[n^1] = bsa_pkg::NS_UNUSED;
                main_tree[n>>1] = bsa_pkg::NS_FREE;
            end
            n = n >> 1;
        end
    endfunction

    function automatic t_grant describe_rec(logic [REC_W-1:0] rec);
        t_grant g;
        int tl;
        int d;
        int n;
        g = '0;
        g.in_slab = rec[REC_W-1];
        n = int'(rec[NODE_W-1:0]);
        tl = g.in_slab ? region_depth() : TOTAL_LEVELS;
        d = depth_of(n);
        if (d > tl) d = tl;
        g.offset = 10'((n - (1 << d)) << (tl - d));
        g.block_log2 = 4'(tl - d);
        return g;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < NODES; i++) begin
            main_tree[i] = bsa_pkg::NS_UNUSED;
            slab_tree[i] = bsa_pkg::NS_UNUSED;
        end
        for (int i = 0; i < MAX_OWNERS; i++) begin
            owner_held[i] = 1'b0;
            owner_rec[i] = '0;
        end
        main_tree[1] = bsa_pkg::NS_FREE;
        slab_tree[1] = bsa_pkg::NS_FREE;
        void'(take_block(1'b0, TOTAL_LEVELS - region_depth()));
    endfunction

    function automatic t_grant place_block(int owner, int k);
        t_grant g;
        bit first_slab;
        bit slab;
        int tl;
        int n;
        first_slab = (k == int'(unit_cfg));
        for (int pass = 0; pass < 2; pass++) begin
            slab = (pass == 0) ? first_slab : !first_slab;
            tl = slab ? region_depth() : TOTAL_LEVELS;
            if (k <= tl) begin
                n = take_block(slab, tl - k);
                if (n != 0) begin
                    owner_rec[owner] = REC_W'(n) | (slab ? (REC_W'(1) << (REC_W-1)) : '0);
                    owner_held[owner] = 1'b1;
                    return describe_rec(owner_rec[owner]);
                end
            end
        end
        g = '0;
        g.status = bsa_pkg::ST_NO_SPACE;
        return g;
    endfunction

    function automatic void drop_owner(int owner);
        release_block(owner_rec[owner][REC_W-1], int'(owner_rec[owner][NODE_W-1:0]));
        owner_held[owner] = 1'b0;
        owner_rec[owner] = '0;
    endfunction

    function automatic t_grant predict_grant(logic [1:0] func, logic [5:0] owner,
                                             logic [10:0] size);
        t_grant g;
        int k;
        k = 0;
        while ((1 << k) < int'(size)) k++;
        g = '0;
        if (func == bsa_pkg::FUNC_RSVD) begin
            g.status = bsa_pkg::ST_NO_BLOCK;
        end else if (func == bsa_pkg::FUNC_ALLOC) begin
            g = place_block(owner, k);
        end else if (!owner_held[owner]) begin
            g.status = bsa_pkg::ST_NO_BLOCK;
        end else if (func == bsa_pkg::FUNC_FREE) begin
            g = describe_rec(owner_rec[owner]);
            drop_owner(owner);
        end else begin
            g = describe_rec(owner_rec[owner]);
            if (int'(g.block_log2) == k) begin
                g.unchanged = 1'b1;
            end else begin
                drop_owner(owner);
                g = place_block(owner, k);
            end
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_grants.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.in_slab !== want.in_slab)
                    report_mismatch("in_slab", rsp_if.in_slab, want.in_slab);
                if (rsp_if.offset !== want.offset)
                    report_mismatch("offset", rsp_if.offset, want.offset);
                if (rsp_if.block_log2 !== want.block_log2)
                    report_mismatch("block_log2", rsp_if.block_log2, want.block_log2);
                if (rsp_if.unchanged !== want.unchanged)
                    report_mismatch("unchanged", rsp_if.unchanged, want.unchanged);
            end
        end
    end

    // Random stalls on the result side
    initial begin
        int wait_n;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_n != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    // Watchdog: count cycles with no transaction; the clearing pass fits well inside
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    bit burst_mode;

    // Leave valid high after a transaction; the next call drops it before any gap, as does drain_results
    task automatic send_request(logic [1:0] func, logic [5:0] owner, logic [10:0] size);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.owner_id   <= owner;
        req_if.size_units <= size;
        do @(posedge i_clk); while (!req_if.ready);
        pending_grants.insert(pending_grants.size(), predict_grant(func, owner, size));
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_config(logic idx, logic [3:0] value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == bsa_pkg::CFG_REGION) region_cfg = value;
        else unit_cfg = value;
        clear_shadow();
    endtask

    function automatic logic [10:0] random_size();
        case ($urandom_range(0, 5))
            0: return 11'($urandom_range(0, 2047));
            1: return 11'(1 << $urandom_range(0, 10));
            2: return 11'(1 << unit_cfg);
            default: return 11'($urandom_range(0, 64));
        endcase
    endfunction

    task automatic test_directed();
        send_request(bsa_pkg::FUNC_FREE, 6'd0, 11'd0);
        send_request(bsa_pkg::FUNC_REALLOC, 6'd1, 11'd4);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd0, 11'd0);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd1, 11'd16);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd2, 11'd1024);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd3, 11'd2047);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd4, 11'd512);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd63, 11'd256);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd5, 11'd256);
        send_request(bsa_pkg::FUNC_REALLOC, 6'd1, 11'd9);
        send_request(bsa_pkg::FUNC_REALLOC, 6'd1, 11'd3);
        send_request(bsa_pkg::FUNC_REALLOC, 6'd4, 11'd1024);
        send_request(bsa_pkg::FUNC_ALLOC, 6'd0, 11'd2);
        send_request(bsa_pkg::FUNC_RSVD, 6'd0, 11'd1);
        send_request(bsa_pkg::FUNC_FREE, 6'd0, 11'd0);
        send_request(bsa_pkg::FUNC_FREE, 6'd1, 11'd1);
        send_request(bsa_pkg::FUNC_FREE, 6'd63, 11'd1);
        send_request(bsa_pkg::FUNC_FREE, 6'd42, 11'h7ff);
    endtask

    task automatic test_config_extremes();
        logic [3:0] regions[4] = '{4'd0, 4'd10, 4'd15, 4'd3};
        logic [3:0] units[4]   = '{4'd0, 4'd10, 4'd15, 4'd2};
        for (int c = 0; c < 4; c++) begin
            write_config(bsa_pkg::CFG_REGION, regions[c]);
            write_config(bsa_pkg::CFG_UNIT, units[c]);
            send_request(bsa_pkg::FUNC_ALLOC, 6'd7,
                         11'(1 << (units[c] > 10 ? 10 : units[c])));
            send_request(bsa_pkg::FUNC_ALLOC, 6'd8, 11'd1);
            send_request(bsa_pkg::FUNC_ALLOC, 6'd9, 11'd1024);
            send_request(bsa_pkg::FUNC_FREE, 6'd7, 11'd0);
        end
    endtask

    task automatic test_random_traffic(int count);
        logic [1:0] func;
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 19);
            func = (r < 9) ? bsa_pkg::FUNC_ALLOC : (r < 13) ? bsa_pkg::FUNC_REALLOC
                 : (r < 19) ? bsa_pkg::FUNC_FREE : bsa_pkg::FUNC_RSVD;
            send_request(func, 6'($urandom_range(0, 15) == 0 ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 15)),
                         random_size());
        end
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 6; p++) begin
            write_config(bsa_pkg::CFG_REGION, 4'($urandom_range(0, 15)));
            write_config(bsa_pkg::CFG_UNIT, 4'($urandom_range(0, 15)));
            test_random_traffic(100);
        end
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        burst_mode = 1'b0;
        region_cfg = 4'd8;
        unit_cfg = 4'd4;
        clear_shadow();
        req_if.valid <= 1'b0;
        req_if.func <= '0;
        req_if.owner_id <= '0;
        req_if.size_units <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= 1'b0;
        cfg_if.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        write_config(bsa_pkg::CFG_REGION, 4'd8);
        write_config(bsa_pkg::CFG_UNIT, 4'd4);
        test_random_traffic(120);
        test_random_configs();

        drain_results();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
